// File: sv/linear_blend_vertex_skinning_top_macros.svh
// Assertion macros for the vertex skinning block.
// Used by lbvs_blend and the top level; expects clk and rst_n in scope.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_TOP_MACROS_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define LBVS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LBVS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lbvs_pkg.sv
// Shared types, constants and saturation helper for the vertex skinning block.
// No dependencies.
`default_nettype none
package lbvs_pkg;

  localparam int NUM_BONES_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WEIGHT_FRAC   = 15;
  localparam int DATA_W        = 32;
  localparam int WEIGHT_W      = 16;
  localparam int BONE_W        = 6;
  localparam int ELEM_W        = 4;
  localparam int ELEMS         = 16;
  localparam int BONES_PER_VTX = 4;
  // wide enough to compare a bone index against a palette size of up to 511
  localparam int CMP_W         = 9;
  localparam int OUT_DEPTH     = 4;
  localparam int CNT_W         = $clog2(OUT_DEPTH + 1);
  localparam int PTR_W         = $clog2(OUT_DEPTH);

  typedef enum logic [1:0] {
    CMD_PAL  = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_INV  = 2'd2,
    CMD_SKIN = 2'd3
  } cmd_t;

  typedef logic [ELEMS-1:0][DATA_W-1:0] mat_t;
  typedef logic [3:0][DATA_W-1:0]       vec_t;

  typedef struct packed {
    logic                           en;
    logic [BONE_W-1:0]              bone;
    logic [ELEM_W-1:0]              elem;
    logic [DATA_W-1:0]              data;
  } pal_wr_t;

  typedef struct packed {
    logic [BONES_PER_VTX-1:0][BONE_W-1:0]   bone;
    logic [BONES_PER_VTX-1:0][WEIGHT_W-1:0] weight;
  } skin_req_t;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] x;
  } res_t;

  // clamp to signed 32 bits; bit 32 flags a clamp
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/lbvs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module lbvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/lbvs_mvec.sv
// Two-stage ROWS x 4 matrix by vector product with floor shift and saturation.
// Depends on lbvs_pkg.
`default_nettype none
module lbvs_mvec #(
  parameter int FRAC_BITS = lbvs_pkg::FRAC_BITS_DEF,
  parameter int ROWS      = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic                    in_ovf,
  input  wire lbvs_pkg::mat_t          mat,
  input  wire lbvs_pkg::vec_t          vec,
  output logic                         out_valid,
  output logic                         out_ovf,
  output logic [ROWS-1:0][31:0]        res
);

  logic signed [63:0] prod_r   [ROWS][4];
  logic signed [63:0] prod_nxt [ROWS][4];
  logic               vld1_r, ovf1_r;
  logic               vld2_r, ovf2_r;
  logic [ROWS-1:0][31:0] res_r, res_nxt;
  logic               ovf_nxt;

  // stage 1: element products, element e = row (e mod 4), column (e / 4)
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_nxt[r][c] = $signed(mat[c*4+r]) * $signed(vec[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    ovf1_r <= in_ovf;
    res_r  <= res_nxt;
    ovf2_r <= ovf_nxt;
  end

  // stage 2: floor shift, row sums, clamp
  always_comb begin
    logic signed [65:0] sum;
    logic signed [63:0] sh;
    logic [32:0]        s;
    ovf_nxt = ovf1_r;
    for (int r = 0; r < ROWS; r++) begin
      sum = '0;
      for (int c = 0; c < 4; c++) begin
        sh  = prod_r[r][c] >>> FRAC_BITS;
        sum = sum + 66'(sh);
      end
      s          = lbvs_pkg::sat32(sum);
      res_nxt[r] = s[31:0];
      ovf_nxt    = ovf_nxt | s[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
    end
  end

  assign out_valid = vld2_r;
  assign out_ovf   = ovf2_r;
  assign res       = res_r;

endmodule
`default_nettype wire

// File: sv/lbvs_blend.sv
// Bone palette (16 RAM banks, one per matrix element) and the weighted blend
// of four bone matrices. Depends on lbvs_pkg, lbvs_ram and the macro header.
`default_nettype none
`include "linear_blend_vertex_skinning_top_macros.svh"
module lbvs_blend #(
  parameter int NUM_BONES = lbvs_pkg::NUM_BONES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lbvs_pkg::pal_wr_t   pal_wr,
  input  wire logic                start,
  input  wire lbvs_pkg::skin_req_t req,
  output logic                     busy,
  output logic                     b_valid,
  output logic                     b_ovf,
  output lbvs_pkg::mat_t           b_mat
);

  localparam int AW = $clog2(NUM_BONES);

  // read sequencer
  logic                     busy_r, busy_nxt;
  logic [1:0]               cnt_r, cnt_nxt;
  lbvs_pkg::skin_req_t      req_r;
  logic [lbvs_pkg::BONE_W-1:0]   rd_bone;
  logic [lbvs_pkg::WEIGHT_W-1:0] rd_w;
  logic [lbvs_pkg::CMP_W-1:0]    rd_ext, wr_ext;
  logic                     rd_inr, wr_inr;

  // pipeline tags
  logic                     s1_vld_r, s1_inr_r, s1_first_r, s1_last_r;
  logic [lbvs_pkg::WEIGHT_W-1:0] s1_w_r;
  logic                     s2_vld_r, s2_first_r, s2_last_r;
  logic                     acc_done_r;
  logic                     b_valid_r;

  logic [31:0]              rdata [lbvs_pkg::ELEMS];
  logic signed [48:0]       prod_r [lbvs_pkg::ELEMS];
  logic signed [48:0]       prod_nxt [lbvs_pkg::ELEMS];
  logic signed [50:0]       acc_r [lbvs_pkg::ELEMS];
  lbvs_pkg::mat_t           bm_r, bm_nxt;
  logic                     bovf_r, bovf_nxt;

  // one bone read per cycle: the first straight from the request word
  always_comb begin
    rd_bone = start ? req.bone[0]   : req_r.bone[cnt_r];
    rd_w    = start ? req.weight[0] : req_r.weight[cnt_r];
    rd_ext  = lbvs_pkg::CMP_W'(rd_bone);
    wr_ext  = lbvs_pkg::CMP_W'(pal_wr.bone);
    rd_inr  = rd_ext < lbvs_pkg::CMP_W'(NUM_BONES);
    wr_inr  = wr_ext < lbvs_pkg::CMP_W'(NUM_BONES);
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd1;
    end else if (busy_r) begin
      cnt_nxt  = cnt_r + 2'd1;
      busy_nxt = (cnt_r != 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      cnt_r      <= 2'd0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      acc_done_r <= 1'b0;
      b_valid_r  <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      cnt_r      <= cnt_nxt;
      s1_vld_r   <= start | busy_r;
      s2_vld_r   <= s1_vld_r;
      acc_done_r <= s2_vld_r & s2_last_r;
      b_valid_r  <= acc_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_r <= req;
    end
    s1_w_r     <= rd_w;
    s1_inr_r   <= rd_inr;
    s1_first_r <= start;
    s1_last_r  <= busy_r && (cnt_r == 2'd3);
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
  end

  // palette banks
  for (genvar e = 0; e < lbvs_pkg::ELEMS; e++) begin : g_bank
    lbvs_ram #(
      .WIDTH (lbvs_pkg::DATA_W),
      .DEPTH (NUM_BONES)
    ) u_bank (
      .clk   (clk),
      .we    (pal_wr.en && wr_inr && (pal_wr.elem == lbvs_pkg::ELEM_W'(e))),
      .waddr (wr_ext[AW-1:0]),
      .wdata (pal_wr.data),
      .raddr (rd_ext[AW-1:0]),
      .rdata (rdata[e])
    );
  end

  // weight products; a bone beyond the palette adds nothing
  always_comb begin
    for (int e = 0; e < lbvs_pkg::ELEMS; e++) begin
      prod_nxt[e] = s1_inr_r ? $signed(rdata[e]) * $signed({1'b0, s1_w_r}) : 49'sd0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    for (int e = 0; e < lbvs_pkg::ELEMS; e++) begin
      if (s2_vld_r) begin
        acc_r[e] <= s2_first_r ? 51'(prod_r[e]) : acc_r[e] + 51'(prod_r[e]);
      end
    end
    bm_r   <= bm_nxt;
    bovf_r <= bovf_nxt;
  end

  // scale back to s15.16 and clamp
  always_comb begin
    logic [32:0] s;
    bovf_nxt = 1'b0;
    for (int e = 0; e < lbvs_pkg::ELEMS; e++) begin
      s         = lbvs_pkg::sat32(66'(acc_r[e] >>> lbvs_pkg::WEIGHT_FRAC));
      bm_nxt[e] = s[31:0];
      bovf_nxt  = bovf_nxt | s[32];
    end
  end

  assign busy    = busy_r;
  assign b_valid = b_valid_r;
  assign b_ovf   = bovf_r;
  assign b_mat   = bm_r;

  `LBVS_ASSERT_IMP(a_no_restart, start, !busy_r, "blend started while reading")
  `LBVS_ASSERT_IMP(a_no_wr_in_rd, pal_wr.en, !busy_r && !start, "palette write during read")
  `LBVS_ASSERT_NXT(a_blend_out, acc_done_r, b_valid_r, "blend result lost")

endmodule
`default_nettype wire

// File: sv/linear_blend_vertex_skinning_top.sv
// Four-bone linear blend skinning unit, top level: stream ports, matrix
// registers, three matrix-vector units, blend unit and result queue.
// Depends on lbvs_pkg, lbvs_blend, lbvs_mvec and the macro header.
//
//  channel | dir | words                                   | handshake
//  in_     | in  | matrix element write or skin vertex     | tvalid/tready
//  out_    | out | skinned x, y, z and overflow flag       | tvalid/tready
//
// A skin word holds the input while its bones are read from the palette
// (one palette read per bone); write words do not hold it.
// Up to 4 results may be in flight or queued; load matrix writes wait until
// no skin word is in flight. rst_n is synchronous; matrix contents are
// undefined until written. Output stalls back up only through the queue.
`default_nettype none
`include "linear_blend_vertex_skinning_top_macros.svh"
module linear_blend_vertex_skinning_top #(
  parameter int NUM_BONES = lbvs_pkg::NUM_BONES_DEF,
  parameter int FRAC_BITS = lbvs_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // element_index, vertex_x, vertex_y, vertex_z, bone_a, bone_b, bone_c,
  // bone_d, weights_ab, weights_cd, zero pad
  input  wire logic [191:0] in_tdata,
  // command
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // skinned_x, skinned_y, skinned_z
  output logic [95:0]       out_tdata,
  // overflow
  output logic [0:0]        out_tuser
);

  lbvs_pkg::cmd_t      cmd;
  logic                in_acc, skin_acc;
  logic [3:0]          elem;
  logic [31:0]         vx, vy, vz;
  lbvs_pkg::pal_wr_t   pal_wr;
  lbvs_pkg::skin_req_t req;

  lbvs_pkg::mat_t lmat_r, imat_r;
  lbvs_pkg::vec_t vtx_r, p_hold_r;
  logic           p_hold_ovf_r;
  logic           inv_go_r;

  logic           blend_busy, b_valid, b_ovf;
  lbvs_pkg::mat_t b_mat;
  logic           p_valid, p_ovf, q_valid, q_ovf, r_valid, r_ovf;
  logic [3:0][31:0] p_res, q_res;
  logic [2:0][31:0] r_res;

  logic [lbvs_pkg::CNT_W-1:0] inflight_r, inflight_nxt;
  logic [lbvs_pkg::CNT_W-1:0] fifo_cnt_r, fifo_cnt_nxt;
  logic [lbvs_pkg::PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  lbvs_pkg::res_t             fifo_r [lbvs_pkg::OUT_DEPTH];
  lbvs_pkg::res_t             head;
  logic                       push, pop;

  // unpack the input word
  always_comb begin
    cmd            = lbvs_pkg::cmd_t'(in_tuser);
    elem           = in_tdata[3:0];
    vx             = in_tdata[35:4];
    vy             = in_tdata[67:36];
    vz             = in_tdata[99:68];
    req.bone[0]    = in_tdata[105:100];
    req.bone[1]    = in_tdata[111:106];
    req.bone[2]    = in_tdata[117:112];
    req.bone[3]    = in_tdata[123:118];
    req.weight[0]  = in_tdata[139:124];
    req.weight[1]  = in_tdata[155:140];
    req.weight[2]  = in_tdata[171:156];
    req.weight[3]  = in_tdata[187:172];
  end

  // accept control: palette port busy, result credit, load matrix interlock
  always_comb begin
    in_tready = !blend_busy;
    if (cmd == lbvs_pkg::CMD_SKIN) begin
      in_tready = !blend_busy &&
                  ((inflight_r + fifo_cnt_r) < lbvs_pkg::CNT_W'(lbvs_pkg::OUT_DEPTH));
    end else if (cmd == lbvs_pkg::CMD_LOAD) begin
      in_tready = !blend_busy && (inflight_r == '0);
    end
    in_acc   = in_tvalid && in_tready;
    skin_acc = in_acc && (cmd == lbvs_pkg::CMD_SKIN);
    pal_wr.en   = in_acc && (cmd == lbvs_pkg::CMD_PAL);
    pal_wr.bone = req.bone[0];
    pal_wr.elem = elem;
    pal_wr.data = vx;
  end

  // load matrix and its inverse, vertex register and held p result
  always_ff @(posedge clk) begin
    if (in_acc && (cmd == lbvs_pkg::CMD_LOAD)) begin
      lmat_r[elem] <= vx;
    end
    if (in_acc && (cmd == lbvs_pkg::CMD_INV)) begin
      imat_r[elem] <= vx;
    end
    if (skin_acc) begin
      vtx_r <= {32'd1 << FRAC_BITS, vz, vy, vx};
    end
    if (p_valid) begin
      p_hold_r     <= p_res;
      p_hold_ovf_r <= p_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_go_r <= 1'b0;
    end else begin
      inv_go_r <= skin_acc;
    end
  end

  // p = Linv * v
  lbvs_mvec #(.FRAC_BITS(FRAC_BITS), .ROWS(4)) u_inv (
    .clk(clk), .rst_n(rst_n), .in_valid(inv_go_r), .in_ovf(1'b0),
    .mat(imat_r), .vec(vtx_r),
    .out_valid(p_valid), .out_ovf(p_ovf), .res(p_res)
  );

  // B = weighted sum of four bones
  lbvs_blend #(.NUM_BONES(NUM_BONES)) u_blend (
    .clk(clk), .rst_n(rst_n), .pal_wr(pal_wr), .start(skin_acc), .req(req),
    .busy(blend_busy), .b_valid(b_valid), .b_ovf(b_ovf), .b_mat(b_mat)
  );

  // q = B * p
  lbvs_mvec #(.FRAC_BITS(FRAC_BITS), .ROWS(4)) u_bone (
    .clk(clk), .rst_n(rst_n), .in_valid(b_valid), .in_ovf(b_ovf | p_hold_ovf_r),
    .mat(b_mat), .vec(p_hold_r),
    .out_valid(q_valid), .out_ovf(q_ovf), .res(q_res)
  );

  // r = L * q, first three rows
  lbvs_mvec #(.FRAC_BITS(FRAC_BITS), .ROWS(3)) u_load (
    .clk(clk), .rst_n(rst_n), .in_valid(q_valid), .in_ovf(q_ovf),
    .mat(lmat_r), .vec(q_res),
    .out_valid(r_valid), .out_ovf(r_ovf), .res(r_res)
  );

  // result queue
  always_comb begin
    push         = r_valid;
    pop          = out_tvalid && out_tready;
    head         = fifo_r[rd_ptr_r];
    fifo_cnt_nxt = fifo_cnt_r + lbvs_pkg::CNT_W'(push) - lbvs_pkg::CNT_W'(pop);
    inflight_nxt = inflight_r + lbvs_pkg::CNT_W'(skin_acc) - lbvs_pkg::CNT_W'(push);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{ovf: r_ovf, z: r_res[2], y: r_res[1], x: r_res[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_cnt_r <= '0;
      inflight_r <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
    end else begin
      fifo_cnt_r <= fifo_cnt_nxt;
      inflight_r <= inflight_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  assign out_tvalid   = (fifo_cnt_r != '0);
  assign out_tdata    = {head.z, head.y, head.x};
  assign out_tuser[0] = head.ovf;

  `LBVS_ASSERT_IMP(a_credit, 1'b1,
      (inflight_r + fifo_cnt_r) <= lbvs_pkg::CNT_W'(lbvs_pkg::OUT_DEPTH),
      "result credit exceeded")
  `LBVS_ASSERT_IMP(a_no_overrun, push && !pop,
      fifo_cnt_r < lbvs_pkg::CNT_W'(lbvs_pkg::OUT_DEPTH), "result queue overrun")
  `LBVS_ASSERT_IMP(a_load_lock, in_acc && (cmd == lbvs_pkg::CMD_LOAD),
      inflight_r == '0, "load matrix written while in use")
  `LBVS_ASSERT_IMP(a_push_owed, push, inflight_r != '0, "result without a skin word")

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the four-bone linear blend skinning unit.
// Depends on lbvs_pkg and linear_blend_vertex_skinning_top; predicts each
// skinned vertex in a local model and checks results in order.
`default_nettype none
module tb_top;

  localparam int NB = 64;
  localparam int FB = 16;
  localparam int LIMIT = 600000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] wcd;
    logic [31:0] wab;
    logic [5:0]  bd;
    logic [5:0]  bc;
    logic [5:0]  bb;
    logic [5:0]  ba;
    logic [31:0] vz;
    logic [31:0] vy;
    logic [31:0] vx;
    logic [3:0]  elem;
  } word_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } skin_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [191:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;
  logic [0:0] out_tuser;

  linear_blend_vertex_skinning_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  // model state
  logic signed [31:0] palette [NB*16];
  logic signed [31:0] load_m [16];
  logic signed [31:0] inv_m [16];
  // bones whose sixteen elements have all been queued for writing
  int wr_bones[$];

  word_t pending_words[$];
  skin_res_t expected_vertices[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 0;

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v, inout bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1; return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1; return -64'sd2147483648;
    end
    return v;
  endfunction

  // row r of m * v, floor-shifted terms summed then clamped
  function automatic logic signed [63:0] mrow(input logic signed [63:0] m[16],
      input logic signed [63:0] v[4], input int r, inout bit ovf);
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    acc = 0;
    for (int c = 0; c < 4; c++) begin
      prod = m[c*4+r] * v[c];
      acc += prod >>> FB;
    end
    return clamp32(acc, ovf);
  endfunction

  function automatic skin_res_t skin_vertex(input word_t w);
    logic signed [63:0] v[4], p[4], q[4], bl[16], lm[16], im[16], acc;
    logic [5:0] bn[4];
    logic [15:0] wt[4];
    bit ovf;
    skin_res_t r;
    ovf = 0;
    bn = '{w.ba, w.bb, w.bc, w.bd};
    wt = '{w.wab[15:0], w.wab[31:16], w.wcd[15:0], w.wcd[31:16]};
    v[0] = $signed(w.vx); v[1] = $signed(w.vy); v[2] = $signed(w.vz);
    v[3] = 64'sd1 <<< FB;
    for (int e = 0; e < 16; e++) begin
      lm[e] = load_m[e]; im[e] = inv_m[e];
    end
    for (int i = 0; i < 4; i++) p[i] = mrow(im, v, i, ovf);
    for (int e = 0; e < 16; e++) begin
      acc = 0;
      for (int k = 0; k < 4; k++)
        acc += palette[bn[k]*16+e] * $signed({48'd0, wt[k]});
      bl[e] = clamp32(acc >>> lbvs_pkg::WEIGHT_FRAC, ovf);
    end
    for (int i = 0; i < 4; i++) q[i] = mrow(bl, p, i, ovf);
    r.x = 32'(mrow(lm, q, 0, ovf));
    r.y = 32'(mrow(lm, q, 1, ovf));
    r.z = 32'(mrow(lm, q, 2, ovf));
    r.ovf = ovf;
    return r;
  endfunction

  // update matrices on each accepted word; queue the expected vertex
  function automatic void accept_word(input word_t w);
    case (lbvs_pkg::cmd_t'(w.cmd))
      lbvs_pkg::CMD_PAL:  palette[w.ba*16+w.elem] = w.vx;
      lbvs_pkg::CMD_LOAD: load_m[w.elem] = w.vx;
      lbvs_pkg::CMD_INV:  inv_m[w.elem] = w.vx;
      lbvs_pkg::CMD_SKIN: expected_vertices.push_back(skin_vertex(w));
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] rnd_val(input int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
      2: return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  // any bone that has been fully written
  function automatic logic [5:0] pick_bone();
    return 6'(wr_bones[$urandom_range(0, wr_bones.size() - 1)]);
  endfunction

  function automatic word_t mk(input lbvs_pkg::cmd_t c, input int e, input logic [31:0] x);
    word_t w;
    w = '0;
    w.cmd = c; w.elem = 4'(e); w.vx = x;
    w.vy = $urandom; w.vz = $urandom; w.wab = $urandom; w.wcd = $urandom;
    w.ba = 6'($urandom); w.bb = 6'($urandom); w.bc = 6'($urandom); w.bd = 6'($urandom);
    return w;
  endfunction

  function automatic word_t mk_skin(input int mode);
    word_t w;
    int wm;
    w = mk(lbvs_pkg::CMD_SKIN, $urandom_range(0, 15), rnd_val(mode));
    w.vy = rnd_val(mode); w.vz = rnd_val(mode);
    // only bones already written may be read
    w.ba = pick_bone(); w.bb = pick_bone(); w.bc = pick_bone(); w.bd = pick_bone();
    wm = $urandom_range(0, 3);
    if (wm == 0) begin
      w.wab = 32'h0000_8000; w.wcd = 0;
    end else if (wm == 1) begin
      w.wab = 32'h2000_2000; w.wcd = 32'h2000_2000;
    end
    return w;
  endfunction

  function automatic void push_matrix(input lbvs_pkg::cmd_t c, input int bone, input int mode);
    word_t w;
    for (int e = 0; e < 16; e++) begin
      if (mode == 0) w = mk(c, e, (e % 5 == 0) ? 32'h1_0000 : 32'h0);
      else w = mk(c, e, rnd_val(mode == 1 ? 1 : $urandom_range(0, 3)));
      w.ba = 6'(bone);
      pending_words.push_back(w);
    end
    if (c == lbvs_pkg::CMD_PAL) wr_bones.push_back(bone);
  endfunction

  // stimulus
  initial begin
    word_t w;
    int far_bones[4];
    far_bones = '{17, 34, 50, 63};
    // identity load, inverse and bone 0 first, then random bones 1..3
    push_matrix(lbvs_pkg::CMD_LOAD, 0, 0);
    push_matrix(lbvs_pkg::CMD_INV, 0, 0);
    for (int b = 0; b < 4; b++) push_matrix(lbvs_pkg::CMD_PAL, b, b == 0 ? 0 : 1);
    // directed vertices: extremes, full weights, zero weights
    for (int m = 0; m < 4; m++) pending_words.push_back(mk_skin(m));
    w = mk_skin(2); w.wab = 32'hFFFF_FFFF; w.wcd = 32'hFFFF_FFFF;
    pending_words.push_back(w);
    w = mk_skin(3); w.wab = 0; w.wcd = 0;
    pending_words.push_back(w);
    // a few bones spread over the palette, with mixed magnitudes
    for (int i = 0; i < 4; i++)
      push_matrix(lbvs_pkg::CMD_PAL, far_bones[i], 1 + (far_bones[i] % 3));
    // random phase: mostly vertices, occasional element rewrites
    for (int i = 0; i < 880; i++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) pending_words.push_back(mk_skin(r % 6 == 0 ? $urandom_range(2, 3) :
                                                 $urandom_range(0, 1)));
      else if (r < 90) begin
        w = mk(lbvs_pkg::CMD_PAL, $urandom_range(0, 15), rnd_val($urandom_range(0, 3)));
        w.ba = pick_bone();
        pending_words.push_back(w);
      end else if (r < 95)
        pending_words.push_back(mk(lbvs_pkg::CMD_LOAD, $urandom_range(0, 15), rnd_val(1)));
      else pending_words.push_back(mk(lbvs_pkg::CMD_INV, $urandom_range(0, 15), rnd_val(1)));
    end
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1;
  end

  // acceptance seen at the last rising edge
  logic in_tready_s = 0;

  // sender: random gap before each word, back to back when the gap is zero
  int send_gap = 0;
  always @(negedge clk) begin
    bit free;
    word_t w;
    if (rst_n) begin
      free = !in_tvalid || in_tready_s;
      if (in_tvalid && in_tready_s)
        send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
      if (free) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_tdata <= {4'b0, w[187:0]};
          in_tuser <= w.cmd;
          in_tvalid <= 1;
        end else begin
          in_tvalid <= 0;
          stim_done = 1;
        end
      end
    end
  end

  // sample acceptance at the rising edge
  always @(posedge clk) begin
    word_t w;
    in_tready_s <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      w = {in_tuser, in_tdata[187:0]};
      accept_word(w);
    end
  end

  // receiver: random stalls, one long hold-off early on
  int recv_gap = 0;
  int long_cnt = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (long_cnt == 0 && cycles > 3000 && cycles < 3010) begin
        long_cnt = 400; out_tready <= 0;
      end else if (long_cnt > 1) begin
        long_cnt--;
      end else begin
        if (long_cnt == 1) long_cnt = -1;
        if (recv_gap > 0) begin
          recv_gap--; out_tready <= 0;
        end else begin
          out_tready <= 1;
          if ($urandom_range(0, 7) == 0) recv_gap = $urandom_range(0, 17);
        end
      end
    end
  end

  // result check
  always @(posedge clk) begin
    skin_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_vertices.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        errors++;
      end else begin
        e = expected_vertices.pop_front();
        if (out_tdata[31:0] !== e.x) begin
          $error("skinned_x exp %h got %h", e.x, out_tdata[31:0]); errors++;
        end
        if (out_tdata[63:32] !== e.y) begin
          $error("skinned_y exp %h got %h", e.y, out_tdata[63:32]); errors++;
        end
        if (out_tdata[95:64] !== e.z) begin
          $error("skinned_z exp %h got %h", e.z, out_tdata[95:64]); errors++;
        end
        if (out_tuser[0] !== e.ovf) begin
          $error("overflow exp %b got %b", e.ovf, out_tuser[0]); errors++;
        end
      end
    end
  end

  // end of run and cycle limit
  int drain = 0;
  always @(posedge clk) begin
    cycles++;
    if (stim_done && !in_tvalid && expected_vertices.size() == 0) drain++;
    if (drain > 40) begin
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
    end else if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end
endmodule
`default_nettype wire

// File: files.f
+incdir+sv
sv/lbvs_pkg.sv
sv/lbvs_ram.sv
sv/lbvs_mvec.sv
sv/lbvs_blend.sv
sv/linear_blend_vertex_skinning_top.sv
tb/tb_top.sv
